[hw/rtl/hall_sector_speed_decoder_top_assert.svh]
// Assertion macros for the hall sector and speed decoder top level.
// Expects signals named clk and arst_n in the scope that uses the macros.
`ifndef HALL_SECTOR_SPEED_DECODER_TOP_ASSERT_SVH
`define HALL_SECTOR_SPEED_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define HSSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HSSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/hssd_pkg.sv]
// Shared types, constants and sector functions for the hall sector and speed decoder.
// No dependencies.
package hssd_pkg;

	localparam int NUM_WIDTH          = 24;
	localparam int SPEED_WIDTH        = 25;
	localparam int PERIOD_WIDTH_DEF   = 32;
	localparam int COUNT_WIDTH_DEF    = 16;
	localparam logic [NUM_WIDTH-1:0] NUM_RESET = 24'd500000;

	localparam logic [2:0] SECTOR_INVALID = 3'd7;
	localparam logic [2:0] SECTOR_LAST    = 3'd5;

	localparam logic signed [1:0] DIR_NONE = 2'sb00;
	localparam logic signed [1:0] DIR_FWD  = 2'sb01;
	localparam logic signed [1:0] DIR_REV  = 2'sb11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} hssd_state_t;

	// Update request from the sequencer to the tracking registers.
	typedef struct packed {
		logic                 upd;
		logic [2:0]           code;
		logic [NUM_WIDTH-1:0] speed;
	} hssd_upd_t;

	// Hall code to sector index; codes 0 and 7 are not valid hall states.
	function automatic logic [2:0] hssd_sector(input logic [2:0] code);
		logic [2:0] idx;
		unique case (code)
			3'd6:    idx = 3'd0;
			3'd4:    idx = 3'd1;
			3'd5:    idx = 3'd2;
			3'd1:    idx = 3'd3;
			3'd3:    idx = 3'd4;
			3'd2:    idx = 3'd5;
			default: idx = SECTOR_INVALID;
		endcase
		return idx;
	endfunction

	// Next sector in the forward direction, wrapping after the last one.
	function automatic logic [2:0] hssd_step_up(input logic [2:0] idx);
		return (idx >= SECTOR_LAST) ? 3'd0 : idx + 3'd1;
	endfunction

	// Electrical angle in degrees of a sector index.
	function automatic logic [8:0] hssd_angle(input logic [2:0] idx);
		logic [8:0] ang;
		unique case (idx)
			3'd0:    ang = 9'd0;
			3'd1:    ang = 9'd60;
			3'd2:    ang = 9'd120;
			3'd3:    ang = 9'd180;
			3'd4:    ang = 9'd240;
			3'd5:    ang = 9'd300;
			default: ang = 9'd0;
		endcase
		return ang;
	endfunction

endpackage

[hw/rtl/hssd_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on hssd_pkg for the dividend width.
module hssd_div import hssd_pkg::*; #(
	parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_WIDTH-1:0]    dividend,
	input  logic [PERIOD_WIDTH-1:0] divisor,
	output logic                    done,
	output logic [NUM_WIDTH-1:0]    quotient
);

	localparam int CNT_W = $clog2(NUM_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WIDTH - 1);

	logic [PERIOD_WIDTH-1:0] rem_q;
	logic [PERIOD_WIDTH-1:0] dsr_q;
	logic [NUM_WIDTH-1:0]    quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [PERIOD_WIDTH:0]   trial;
	logic [PERIOD_WIDTH:0]   diff;
	logic                    fits;

	// A zero divisor never borrows, so the quotient comes out all ones,
	// which is exactly the saturated speed.
	assign trial = {rem_q, quo_q[NUM_WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[PERIOD_WIDTH-1:0] : trial[PERIOD_WIDTH-1:0];
			quo_q <= {quo_q[NUM_WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/hssd_track.sv]
// Sector, direction, signed speed and position count registers.
// Depends on hssd_pkg for the sector map and the update struct.
module hssd_track import hssd_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hssd_upd_t                     upd,
	output logic [2:0]                    sector,
	output logic signed [1:0]             dir,
	output logic signed [SPEED_WIDTH-1:0] speed,
	output logic [COUNT_WIDTH-1:0]        count
);

	logic [2:0]                    sec_q;
	logic signed [1:0]             dir_q;
	logic signed [SPEED_WIDTH-1:0] spd_q;
	logic [COUNT_WIDTH-1:0]        cnt_q;
	logic [2:0]                    nxt;
	logic signed [1:0]             dir_new;
	logic signed [1:0]             dir_eff;
	logic [SPEED_WIDTH-1:0]        mag;

	assign nxt = hssd_sector(upd.code);
	assign mag = {1'b0, upd.speed};

	always_comb begin
		if (nxt == hssd_step_up(sec_q)) begin
			dir_new = DIR_FWD;
		end else if (sec_q == hssd_step_up(nxt)) begin
			dir_new = DIR_REV;
		end else begin
			dir_new = DIR_NONE;
		end
		// An invalid hall code keeps the stored direction in force.
		dir_eff = (nxt == SECTOR_INVALID) ? dir_q : dir_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= '0;
			dir_q <= DIR_NONE;
			spd_q <= '0;
			cnt_q <= '0;
		end else if (upd.upd) begin
			if (nxt != SECTOR_INVALID) begin
				sec_q <= nxt;
				dir_q <= dir_new;
			end
			if (dir_eff == DIR_FWD) begin
				spd_q <= mag;
				cnt_q <= cnt_q + COUNT_WIDTH'(1);
			end else if (dir_eff == DIR_REV) begin
				spd_q <= SPEED_WIDTH'(0) - mag;
				cnt_q <= cnt_q - COUNT_WIDTH'(1);
			end
		end
	end

	assign sector = sec_q;
	assign dir    = dir_q;
	assign speed  = spd_q;
	assign count  = cnt_q;

endmodule

[hw/rtl/hall_sector_speed_decoder_top.sv]
// Top level of the hall sector and speed decoder: sequencer, numerator register, output flag.
// Depends on hssd_pkg, hssd_div, hssd_track and the assertion macro header.
//
// Usage. Each hall edge is presented as one item on the input channel (in_valid/in_ready)
// carrying hall_code and capture_period. The block answers every item with exactly one
// item on the output channel (out_valid/out_ready): the sector angle, the direction,
// the signed speed and the position count after that edge.
// The speed is speed_numerator divided by the low PERIOD_WIDTH bits of the period,
// truncated; a zero period gives the all-ones maximum. The numerator is written through
// the cfg_valid/cfg_ready channel, which is always ready; write it only while idle.
// Rate. A shared restoring divider produces one quotient bit per cycle. out_valid rises
// when the result is registered, and in_ready returns at the same edge, so the block takes
// no new item while one is in the divider or waiting to be committed. While a result waits
// to be taken, the next item is still accepted and divided; its update is held until the
// output is free, so a stalled receiver only delays the result and loses nothing.
// Reset. arst_n clears the sector to index zero, the direction, the speed and the count
// to zero, the numerator to 500000, and empties the output.
`include "hall_sector_speed_decoder_top_assert.svh"

module hall_sector_speed_decoder_top import hssd_pkg::*; #(
	parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [NUM_WIDTH-1:0]          speed_numerator,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    hall_code,
	input  logic [31:0]                   capture_period,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [8:0]                    sector_angle,
	output logic signed [1:0]             direction,
	output logic signed [SPEED_WIDTH-1:0] signed_speed,
	output logic signed [15:0]            position_count
);

	hssd_state_t state_q, state_d;

	logic [NUM_WIDTH-1:0]   num_q;
	logic [2:0]             code_q;
	logic                   out_valid_q;
	logic                   in_acc;
	logic                   div_done;
	logic [NUM_WIDTH-1:0]   quo;
	logic                   slot_free;
	logic                   commit;
	hssd_upd_t              upd;
	logic [2:0]             sector;
	logic [COUNT_WIDTH-1:0] count;
	logic [31:0]            count_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;

	// The output slot is free when it is empty or is being emptied this cycle.
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_q <= speed_numerator;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_q <= hall_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: wait for an item, run the divider, then commit the update once the
	// output slot can take the new result.
	always_comb begin
		state_d = state_q;
		commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (slot_free) begin
						commit  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	hssd_div #(
		.PERIOD_WIDTH(PERIOD_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.dividend (num_q),
		.divisor  (capture_period[PERIOD_WIDTH-1:0]),
		.done     (div_done),
		.quotient (quo)
	);

	assign upd.upd   = commit;
	assign upd.code  = code_q;
	assign upd.speed = quo;

	// The tracking registers change only on a commit, which happens only when the
	// output slot is free, so they double as the output payload.
	hssd_track #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.sector (sector),
		.dir    (direction),
		.speed  (signed_speed),
		.count  (count)
	);

	// The count wraps at its own width and is then shown in 16 bits.
	assign count_ext      = 32'(count);
	assign position_count = count_ext[15:0];
	assign sector_angle   = hssd_angle(sector);
	assign out_valid      = out_valid_q;

	`HSSD_ASSERT_NXT(a_accept_starts_div, in_acc, state_q == ST_DIV,
		"accepted item did not start the divider")
	`HSSD_ASSERT_IMP(a_done_in_div, div_done, state_q == ST_DIV,
		"divider finished outside the divide state")
	`HSSD_ASSERT_IMP(a_rise_after_work, $rose(out_valid_q),
		$past(state_q) == ST_DIV || $past(state_q) == ST_HOLD,
		"result appeared without a finished division")
	`HSSD_ASSERT_IMP(a_count_moves_on_result, !$stable(count), $rose(out_valid_q) ||
		(out_valid_q && $past(out_valid_q) && $past(out_ready)),
		"position count changed without a new result")

endmodule

[sim/hall_sector_speed_decoder_checker.sv]
`timescale 1ns / 1ps
// Checker for the hall sector and speed decoder: follows numerator writes, predicts the
// result of each accepted hall edge and compares it with the output channel.
// Depends on hssd_pkg.
module hall_sector_speed_decoder_checker import hssd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [NUM_WIDTH-1:0]          speed_numerator,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [2:0]                    hall_code,
	input  logic [31:0]                   capture_period,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [8:0]                    sector_angle,
	input  logic signed [1:0]             direction,
	input  logic signed [SPEED_WIDTH-1:0] signed_speed,
	input  logic signed [15:0]            position_count,
	output int                            fail_count,
	output int                            pending_edges,
	output int                            checked_edges
);

	typedef struct packed {
		logic [8:0]                    angle;
		logic signed [1:0]             dir;
		logic signed [SPEED_WIDTH-1:0] speed;
		logic signed [15:0]            pos;
	} edge_result_t;

	localparam logic [NUM_WIDTH-1:0] SPEED_SAT = '1;

	logic [NUM_WIDTH-1:0]          numerator;
	logic [2:0]                    sector;
	logic signed [1:0]             dir_now;
	logic signed [SPEED_WIDTH-1:0] speed_now;
	logic signed [15:0]            edge_pos;
	edge_result_t                  expected_edges[$];
	int                            fails;
	int                            checked;

	function automatic logic [2:0] sector_of(input logic [2:0] code);
		case (code)
			3'd6: return 3'd0;
			3'd4: return 3'd1;
			3'd5: return 3'd2;
			3'd1: return 3'd3;
			3'd3: return 3'd4;
			3'd2: return 3'd5;
			default: return SECTOR_INVALID;
		endcase
	endfunction

	// Advances the tracked motor state by one hall edge and returns what the block should report.
	function automatic edge_result_t decode_hall_edge(input logic [2:0] code,
			input logic [31:0] period);
		logic [31:0]  quotient;
		logic [2:0]   next_sector;
		edge_result_t res;
		if (period == 32'd0)
			quotient = {8'd0, SPEED_SAT};
		else
			quotient = {8'd0, numerator} / period;
		next_sector = sector_of(code);
		if (next_sector != SECTOR_INVALID) begin
			if (next_sector == ((sector == 3'd5) ? 3'd0 : sector + 3'd1))
				dir_now = DIR_FWD;
			else if (sector == ((next_sector == 3'd5) ? 3'd0 : next_sector + 3'd1))
				dir_now = DIR_REV;
			else
				dir_now = DIR_NONE;
			sector = next_sector;
		end
		if (dir_now == DIR_FWD) begin
			speed_now = $signed({1'b0, quotient[NUM_WIDTH-1:0]});
			edge_pos  = edge_pos + 16'sd1;
		end else if (dir_now == DIR_REV) begin
			speed_now = -$signed({1'b0, quotient[NUM_WIDTH-1:0]});
			edge_pos  = edge_pos - 16'sd1;
		end
		res.angle = {6'd0, sector} * 9'd60;
		res.dir   = dir_now;
		res.speed = speed_now;
		res.pos   = edge_pos;
		return res;
	endfunction

	function automatic int field_bad(input string name, input longint want, input longint got);
		if (want == got)
			return 0;
		$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		edge_result_t want;
		if (!arst_n) begin
			numerator = NUM_RESET;
			sector    = 3'd0;
			dir_now   = DIR_NONE;
			speed_now = '0;
			edge_pos  = '0;
			expected_edges.delete();
			fails     = 0;
			checked   = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				numerator = speed_numerator;
			if (out_valid && out_ready) begin
				if (expected_edges.size() == 0) begin
					$display("%0t: result with no edge pending, angle %0d direction %0d",
						$time, sector_angle, direction);
					fails++;
				end else begin
					want = expected_edges.pop_front();
					fails += field_bad("sector_angle", want.angle, sector_angle);
					fails += field_bad("direction", want.dir, direction);
					fails += field_bad("signed_speed", want.speed, signed_speed);
					fails += field_bad("position_count", want.pos, position_count);
					checked++;
				end
			end
			if (in_valid && in_ready)
				expected_edges.push_back(decode_hall_edge(hall_code, capture_period));
		end
		fail_count    <= fails;
		pending_edges <= expected_edges.size();
		checked_edges <= checked;
	end

endmodule

[sim/hall_sector_speed_decoder_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the hall sector and speed decoder: clock, reset, stimulus and verdict.
// Depends on hssd_pkg, the decoder RTL and hall_sector_speed_decoder_checker.
module hall_sector_speed_decoder_top_tb;
	import hssd_pkg::*;

	// The cycle limit leaves room for several times the slowest correct run, stalls and gaps included.
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASE_EDGES = 220;

	// Hall codes in forward sector order, sector 0 in the low bits.
	localparam logic [17:0] RING_CODES = {3'd2, 3'd3, 3'd1, 3'd5, 3'd4, 3'd6};
	// The two codes that no healthy sensor set produces.
	localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
	localparam logic [2:0] HALL_ALL_HIGH = 3'd7;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [NUM_WIDTH-1:0]          speed_numerator;
	logic                          in_valid;
	logic                          in_ready;
	logic [2:0]                    hall_code;
	logic [31:0]                   capture_period;
	logic                          out_valid;
	logic                          out_ready;
	logic [8:0]                    sector_angle;
	logic signed [1:0]             direction;
	logic signed [SPEED_WIDTH-1:0] signed_speed;
	logic signed [15:0]            position_count;

	int fail_count;
	int pending_edges;
	int checked_edges;
	int cycle_count;
	int edges_sent;
	int settings_used;
	int ring_pos;
	bit idling_on = 1'b1;
	bit hold_request = 1'b0;

	hall_sector_speed_decoder_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.speed_numerator(speed_numerator),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.hall_code      (hall_code),
		.capture_period (capture_period),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sector_angle   (sector_angle),
		.direction      (direction),
		.signed_speed   (signed_speed),
		.position_count (position_count)
	);

	// The checker sees the same pins as the block and does all of the prediction.
	hall_sector_speed_decoder_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.speed_numerator(speed_numerator),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.hall_code      (hall_code),
		.capture_period (capture_period),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sector_angle   (sector_angle),
		.direction      (direction),
		.signed_speed   (signed_speed),
		.position_count (position_count),
		.fail_count     (fail_count),
		.pending_edges  (pending_edges),
		.checked_edges  (checked_edges)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offers one hall edge and holds it until the block takes it. Afterwards the input
	// may go quiet for a short burst, so gaps land at every point of the divide.
	task automatic send_edge(input logic [2:0] code, input logic [31:0] period);
		in_valid       <= 1'b1;
		hall_code      <= code;
		capture_period <= period;
		do @(posedge clk); while (!in_ready);
		edges_sent++;
		// Keep our own idea of the rotor sector so random steps stay adjacent.
		for (int i = 0; i < 6; i++)
			if (RING_CODES[i*3 +: 3] == code)
				ring_pos = i;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stops offering edges and waits until every expected result has come back. The
	// extra cycles give a stray late result the chance to show up.
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_edges != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_numerator(input logic [NUM_WIDTH-1:0] value);
		cfg_valid       <= 1'b1;
		speed_numerator <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Periods from zero through short and long ones up to the full 32-bit range, so the
	// quotient runs from saturation down to zero.
	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1, 2:    return $urandom_range(1, 16);
			3, 4, 5: return $urandom_range(17, 1 << 20);
			6:       return $urandom_range(1, 32'h00FF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// Mostly a motor turning one way or the other, with the odd skipped sector and the
	// odd invalid code mixed in.
	task automatic send_random_edge();
		int pick;
		logic [2:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			ring_pos = (ring_pos == 5) ? 0 : ring_pos + 1;
		else if (pick < 75)
			ring_pos = (ring_pos == 0) ? 5 : ring_pos - 1;
		else if (pick < 85)
			ring_pos = $urandom_range(0, 5);
		if (pick < 85)
			code = RING_CODES[ring_pos*3 +: 3];
		else
			code = pick[0] ? HALL_ALL_HIGH : HALL_ALL_LOW;
		send_edge(code, pick_period());
	endtask

	// The receiver either honors a request for one long hold, idles in short bursts, or
	// takes results. The long hold lets the block fill up and push back on its input.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				for (int n = 0; n < LONG_HOLD; n++)
					@(posedge clk);
				hold_request = 1'b0;
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("hall_sector_speed_decoder_top verification failed");
		$finish;
	end

	initial begin
		logic [NUM_WIDTH-1:0] phase_num [5];
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		speed_numerator = NUM_RESET;
		in_valid        = 1'b0;
		hall_code       = 3'd0;
		capture_period  = 32'd0;
		edges_sent      = 0;
		settings_used   = 1;
		ring_pos        = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges at the reset numerator. The first one steps backward out of
		// sector zero so the count wraps below zero straight away.
		send_edge(3'd2, 32'd0);
		send_edge(3'd6, 32'd1);
		send_edge(3'd4, 32'hFFFF_FFFF);
		send_edge(3'd5, 32'd0);
		send_edge(3'd1, 32'd500000);
		send_edge(3'd3, 32'd7);
		send_edge(3'd2, 32'd3);
		send_edge(3'd6, 32'd499999);
		// Invalid codes while turning forward: sector held, count still steps.
		send_edge(HALL_ALL_LOW, 32'd1000);
		send_edge(HALL_ALL_HIGH, 32'd0);
		// Reverse through the wrap point, with a saturated and a zero speed.
		send_edge(3'd2, 32'd250000);
		send_edge(3'd3, 32'd0);
		send_edge(3'd1, 32'h8000_0000);
		// A skipped sector clears the direction; after that nothing moves.
		send_edge(3'd6, 32'd5);
		send_edge(HALL_ALL_HIGH, 32'd9);
		send_edge(3'd6, 32'd9);
		settle_idle();

		// Largest numerator: a period of one gives the full speed, here in the reverse direction.
		write_numerator(24'hFF_FFFF);
		send_edge(3'd2, 32'd1);
		send_edge(3'd3, 32'd2);
		send_edge(3'd2, 32'h00FF_FFFF);
		send_edge(HALL_ALL_LOW, 32'h0100_0000);
		settle_idle();

		phase_num[0] = 24'hFF_FFFF;
		phase_num[1] = 24'd1;
		phase_num[2] = NUM_WIDTH'($urandom_range(1, 24'hFF_FFFF));
		phase_num[3] = NUM_WIDTH'($urandom_range(2, 4095));
		phase_num[4] = NUM_RESET;
		for (int p = 0; p < 5; p++) begin
			write_numerator(phase_num[p]);
			for (int k = 0; k < PHASE_EDGES; k++) begin
				// One long receiver hold while edges keep coming.
				if (p == 1 && k == 50)
					hold_request = 1'b1;
				// One pause on the sending side until everything has drained.
				if (p == 2 && k == 100)
					settle_idle();
				// The tail of the run goes at full rate on both sides.
				if (p == 4 && k == 70)
					idling_on = 1'b0;
				send_random_edge();
			end
			settle_idle();
		end

		repeat (30) @(posedge clk);
		$display("Run covered %0d hall edges under %0d numerator settings, %0d results compared,",
			edges_sent, settings_used, checked_edges);
		$display("with invalid codes, zero and full-width periods, a long stall and a drain.");
		if (fail_count == 0 && pending_edges == 0)
			$display("hall_sector_speed_decoder_top verification clean");
		else
			$display("hall_sector_speed_decoder_top verification failed");
		$finish;
	end

endmodule
